// ===== src/erw_pkg.sv =====
// ----------------------------------------------------------------------------
// erw_pkg
// Shared types, register indexes and saturation helper for the event
// rotation warp pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package erw_pkg;

    typedef logic signed [31:0] t_word;

    // configuration register indexes
    typedef enum logic [2:0] {
        CFG_ANG_VEL_X      = 3'd0,
        CFG_ANG_VEL_Y      = 3'd1,
        CFG_ANG_VEL_Z      = 3'd2,
        CFG_USE_REFERENCE  = 3'd3,
        CFG_REFERENCE_TIME = 3'd4,
        CFG_PARTIAL_ENABLE = 3'd5,
        CFG_PARTIAL_COUNT  = 3'd6
    } t_cfg_idx;

    // per-event warp mode, decided at the front of the pipe
    typedef enum logic [1:0] {
        MODE_THRU  = 2'd0,  // zero velocity, bearing unchanged
        MODE_WHOLE = 2'd1,  // first and second order terms
        MODE_FIRST = 2'd2,  // first order term only
        MODE_PASS  = 2'd3   // x, y unchanged, z forced to one
    } t_mode;

    // configuration register set
    typedef struct packed {
        logic signed [31:0] ang_vel_x;
        logic signed [31:0] ang_vel_y;
        logic signed [31:0] ang_vel_z;
        logic               use_reference;
        logic signed [31:0] reference_time;
        logic               partial_enable;
        logic        [16:0] partial_count;
    } t_cfg;

    // event payload carried down the pipe
    typedef struct packed {
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] z;
        logic signed [31:0] t;
        t_mode              mode;
        logic               last;
    } t_evt;

    localparam logic signed [31:0] Q428_ONE = 32'sh1000_0000;

    // clamp a wide signed value to signed 32 bits
    function automatic logic signed [31:0] sat32(input logic signed [40:0] v);
        logic signed [31:0] r;
        if (v > 41'sh0_7FFF_FFFF) begin
            r = 32'sh7FFF_FFFF;
        end else if (v < -41'sh0_8000_0000) begin
            r = 32'sh8000_0000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// ===== src/erw_front.sv =====
// ----------------------------------------------------------------------------
// erw_front
// Entry stage: time offset with optional reference, bundle index counter and
// per-event mode decision, registered into the first pipeline stage.
// ----------------------------------------------------------------------------
`default_nettype none

module erw_front
    import erw_pkg::*;
#(
    parameter int MAX_BUNDLE = 65536
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire t_cfg         i_cfg,
    input  wire logic         i_accept,   // input transaction this cycle
    input  wire logic         i_load,     // stage register may load
    input  wire logic [127:0] i_data,     // x_in, y_in, z_in, time_offset
    input  wire logic         i_last,
    output t_evt              o_evt
);

    localparam int IDX_W = $clog2(MAX_BUNDLE + 1);
    localparam int CMP_W = (IDX_W > 17) ? IDX_W : 17;

    logic [IDX_W-1:0]   r_idx;
    logic [IDX_W-1:0]   n_idx;
    logic signed [31:0] w_t_raw;
    logic signed [31:0] w_t;
    logic               w_w_zero;
    t_mode              w_mode;
    t_evt               r_evt;

    assign w_t_raw = $signed(i_data[127:96]);

    // event time, optionally relative to the reference time
    always_comb begin
        if (i_cfg.use_reference) begin
            w_t = sat32(41'(w_t_raw) - 41'(i_cfg.reference_time));
        end else begin
            w_t = w_t_raw;
        end
    end

    // mode decision
    assign w_w_zero = (i_cfg.ang_vel_x == '0) && (i_cfg.ang_vel_y == '0)
                   && (i_cfg.ang_vel_z == '0);

    always_comb begin
        if (w_w_zero) begin
            w_mode = MODE_THRU;
        end else if (!i_cfg.partial_enable) begin
            w_mode = MODE_WHOLE;
        end else if (CMP_W'(r_idx) < CMP_W'(i_cfg.partial_count)) begin
            w_mode = MODE_FIRST;
        end else begin
            w_mode = MODE_PASS;
        end
    end

    // bundle index, restarts after the last event, holds at the bundle limit
    always_comb begin
        n_idx = r_idx;
        if (i_accept) begin
            if (i_last) begin
                n_idx = '0;
            end else if (r_idx < IDX_W'(MAX_BUNDLE)) begin
                n_idx = r_idx + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx <= '0;
        end else begin
            r_idx <= n_idx;
        end
    end

    // first pipeline stage
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_evt.x    <= $signed(i_data[31:0]);
            r_evt.y    <= $signed(i_data[63:32]);
            r_evt.z    <= $signed(i_data[95:64]);
            r_evt.t    <= w_t;
            r_evt.mode <= w_mode;
            r_evt.last <= i_last;
        end
    end

    assign o_evt = r_evt;

endmodule

`default_nettype wire

// ===== src/erw_cross.sv =====
// ----------------------------------------------------------------------------
// erw_cross
// Two-stage saturating cross product w x v: six registered 32x32 products,
// then shifted differences clamped to Q4.28.
// ----------------------------------------------------------------------------
`default_nettype none

module erw_cross
    import erw_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_en_mul,   // product stage may load
    input  wire logic  i_en_sum,   // difference stage may load
    input  wire t_word i_w [3],
    input  wire t_word i_v [3],
    output t_word      o_r [3]
);

    logic signed [63:0] r_prod [6];
    t_word              r_res  [3];
    logic signed [40:0] w_diff [3];

    // product stage
    always_ff @(posedge i_clk) begin
        if (i_en_mul) begin
            r_prod[0] <= i_w[1] * i_v[2];
            r_prod[1] <= i_w[2] * i_v[1];
            r_prod[2] <= i_w[2] * i_v[0];
            r_prod[3] <= i_w[0] * i_v[2];
            r_prod[4] <= i_w[0] * i_v[1];
            r_prod[5] <= i_w[1] * i_v[0];
        end
    end

    // each product floored by 24 on its own, then differenced
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            w_diff[k] = 41'(r_prod[2*k] >>> 24) - 41'(r_prod[2*k+1] >>> 24);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en_sum) begin
            for (int k = 0; k < 3; k++) begin
                r_res[k] <= sat32(w_diff[k]);
            end
        end
    end

    assign o_r = r_res;

endmodule

`default_nettype wire

// ===== src/event_rotation_warp_core.sv =====
// ----------------------------------------------------------------------------
// event_rotation_warp_core
// Warps a stream of event bearings by one constant angular velocity with a
// second order series of the rotation. One event enters per clock cycle when
// the output side keeps up; the result of an event passes through seven
// register stages before it is presented on the output:
// the entry stage (time offset, mode), the product and combine stages of
// w x p, the product and combine stages of w x c with c*t alongside, the
// d*t^2/2 product, and the output register after the final clamp. A stall on
// the output holds the pipe; empty stages still fill, so input is taken while
// a result waits.
// Configuration is written through its own channel, which is always ready,
// and must only change while no event is in flight.
// ----------------------------------------------------------------------------
`default_nettype none

module event_rotation_warp_core
    import erw_pkg::*;
#(
    parameter int MAX_BUNDLE = 65536
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    // configuration write channel
    input  wire logic         i_cfg_valid,
    output logic              o_cfg_ready,
    input  wire logic [2:0]   i_cfg_index,
    input  wire logic [31:0]  i_cfg_data,
    // event input
    input  wire logic         i_s_axis_tvalid,
    output logic              o_s_axis_tready,
    input  wire logic [127:0] i_s_axis_tdata,  // x_in, y_in, z_in, time_offset
    input  wire logic         i_s_axis_tlast,  // last_event
    // warped event output
    output logic              o_m_axis_tvalid,
    input  wire logic         i_m_axis_tready,
    output logic [95:0]       o_m_axis_tdata,  // x_out, y_out, z_out
    output logic              o_m_axis_tlast   // last_out
);

    localparam int NST = 7;

    t_cfg               r_cfg;
    logic [NST-1:0]     r_vld;
    logic [NST:0]       w_rdy;
    logic               w_accept;

    t_evt               w_evt0;
    t_evt               r_evt1, r_evt2, r_evt3, r_evt4, r_evt5;
    logic signed [63:0] r_tt1;
    logic signed [32:0] r_h2, r_h3, r_h4;
    logic signed [63:0] r_ct3   [3];
    logic signed [33:0] r_ctsh4 [3];
    logic signed [33:0] r_ctsh5 [3];
    logic signed [64:0] r_dh5   [3];
    t_word              w_w     [3];
    t_word              w_p1    [3];
    t_word              w_c     [3];
    t_word              w_d     [3];
    t_word              w_p5    [3];
    logic signed [36:0] w_sum   [3];
    t_word              w_res   [3];
    t_word              r_out   [3];
    logic               r_out_last;

    // configuration registers
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_ANG_VEL_X:      r_cfg.ang_vel_x      <= $signed(i_cfg_data);
                CFG_ANG_VEL_Y:      r_cfg.ang_vel_y      <= $signed(i_cfg_data);
                CFG_ANG_VEL_Z:      r_cfg.ang_vel_z      <= $signed(i_cfg_data);
                CFG_USE_REFERENCE:  r_cfg.use_reference  <= i_cfg_data[0];
                CFG_REFERENCE_TIME: r_cfg.reference_time <= $signed(i_cfg_data);
                CFG_PARTIAL_ENABLE: r_cfg.partial_enable <= i_cfg_data[0];
                CFG_PARTIAL_COUNT:  r_cfg.partial_count  <= i_cfg_data[16:0];
                default: ;
            endcase
        end
    end

    // pipeline flow control: a stage loads when empty or when it moves on
    always_comb begin
        w_rdy[NST] = i_m_axis_tready;
        for (int k = NST - 1; k >= 0; k--) begin
            w_rdy[k] = !r_vld[k] || w_rdy[k+1];
        end
    end

    assign w_accept        = i_s_axis_tvalid && w_rdy[0];
    assign o_s_axis_tready = w_rdy[0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (w_rdy[0]) begin
                r_vld[0] <= i_s_axis_tvalid;
            end
            for (int k = 1; k < NST; k++) begin
                if (w_rdy[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    // stage 0: time, index and mode
    erw_front #(
        .MAX_BUNDLE (MAX_BUNDLE)
    ) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (r_cfg),
        .i_accept (w_accept),
        .i_load   (w_rdy[0]),
        .i_data   (i_s_axis_tdata),
        .i_last   (i_s_axis_tlast),
        .o_evt    (w_evt0)
    );

    assign w_w[0] = r_cfg.ang_vel_x;
    assign w_w[1] = r_cfg.ang_vel_y;
    assign w_w[2] = r_cfg.ang_vel_z;

    assign w_p1[0] = w_evt0.x;
    assign w_p1[1] = w_evt0.y;
    assign w_p1[2] = w_evt0.z;

    // stages 1 and 2: c = w x p
    erw_cross u_cross_c (
        .i_clk    (i_clk),
        .i_en_mul (w_rdy[1]),
        .i_en_sum (w_rdy[2]),
        .i_w      (w_w),
        .i_v      (w_p1),
        .o_r      (w_c)
    );

    // stages 3 and 4: d = w x c
    erw_cross u_cross_d (
        .i_clk    (i_clk),
        .i_en_mul (w_rdy[3]),
        .i_en_sum (w_rdy[4]),
        .i_w      (w_w),
        .i_v      (w_c),
        .o_r      (w_d)
    );

    // stage 1: t squared
    always_ff @(posedge i_clk) begin
        if (w_rdy[1]) begin
            r_evt1 <= w_evt0;
            r_tt1  <= w_evt0.t * w_evt0.t;
        end
    end

    // stage 2: h = t^2 / 2, floor of a non-negative value
    always_ff @(posedge i_clk) begin
        if (w_rdy[2]) begin
            r_evt2 <= r_evt1;
            r_h2   <= {1'b0, r_tt1[62:31]};
        end
    end

    // stage 3: c * t
    always_ff @(posedge i_clk) begin
        if (w_rdy[3]) begin
            r_evt3 <= r_evt2;
            r_h3   <= r_h2;
            for (int k = 0; k < 3; k++) begin
                r_ct3[k] <= w_c[k] * r_evt2.t;
            end
        end
    end

    // stage 4: first order term in Q4.28
    always_ff @(posedge i_clk) begin
        if (w_rdy[4]) begin
            r_evt4 <= r_evt3;
            r_h4   <= r_h3;
            for (int k = 0; k < 3; k++) begin
                r_ctsh4[k] <= 34'(r_ct3[k] >>> 30);
            end
        end
    end

    // stage 5: d * h
    always_ff @(posedge i_clk) begin
        if (w_rdy[5]) begin
            r_evt5 <= r_evt4;
            for (int k = 0; k < 3; k++) begin
                r_ctsh5[k] <= r_ctsh4[k];
                r_dh5[k]   <= 65'(w_d[k]) * 65'(r_h4);
            end
        end
    end

    // final sum and clamp, then mode select
    assign w_p5[0] = r_evt5.x;
    assign w_p5[1] = r_evt5.y;
    assign w_p5[2] = r_evt5.z;

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            w_sum[k] = 37'(w_p5[k]) + 37'(r_ctsh5[k]);
            if (r_evt5.mode == MODE_WHOLE) begin
                w_sum[k] = w_sum[k] + 37'(r_dh5[k] >>> 30);
            end
        end
        case (r_evt5.mode)
            MODE_THRU: begin
                w_res = w_p5;
            end
            MODE_PASS: begin
                w_res[0] = w_p5[0];
                w_res[1] = w_p5[1];
                w_res[2] = Q428_ONE;
            end
            default: begin
                for (int k = 0; k < 3; k++) begin
                    w_res[k] = sat32(41'(w_sum[k]));
                end
            end
        endcase
    end

    // stage 6: output register
    always_ff @(posedge i_clk) begin
        if (w_rdy[6]) begin
            r_out      <= w_res;
            r_out_last <= r_evt5.last;
        end
    end

    assign o_m_axis_tvalid = r_vld[NST-1];
    assign o_m_axis_tdata  = {r_out[2], r_out[1], r_out[0]};
    assign o_m_axis_tlast  = r_out_last;

endmodule

`default_nettype wire

// ===== src/erw_checker.sv =====
// ----------------------------------------------------------------------------
// erw_checker
// Port-level checks on the event rotation warp core, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module erw_checker (
    input wire logic         i_clk,
    input wire logic         i_rst_n,
    input wire logic         o_s_axis_tready,
    input wire logic         o_m_axis_tvalid,
    input wire logic         i_m_axis_tready,
    input wire logic [95:0]  o_m_axis_tdata,
    input wire logic         o_m_axis_tlast,
    input wire logic         o_cfg_ready
);

    // no result right after reset
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid)
        else $error("output valid after reset");

    // a stalled result holds its value
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=>
            o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tlast))
        else $error("stalled result changed");

    // an empty output stage never blocks the input
    a_empty_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_m_axis_tvalid |-> o_s_axis_tready)
        else $error("input blocked with empty output");

    // configuration channel never stalls
    a_cfg_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cfg_ready)
        else $error("configuration channel not ready");

endmodule

bind event_rotation_warp_core erw_checker u_erw_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_s_axis_tready (o_s_axis_tready),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata),
    .o_m_axis_tlast  (o_m_axis_tlast),
    .o_cfg_ready     (o_cfg_ready)
);

`default_nettype wire
